// ===== sv/tmcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants for the text-mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  // Request operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Control character codes
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Blank cell contents
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;

  // Tab stop spacing
  localparam int TAB_STOP = 8;

  // Store action decoded from one put request
  typedef struct packed {
    logic store_char;  // write the code at the cursor
    logic scroll;      // move the frame up one row and blank the last row
    logic clear;       // blank the whole frame
  } tmcw_act_t;

endpackage

// ===== sv/tmcw_ram.sv =====
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tmcw_cursor.sv =====
// ----------------------------------------------------------------------------
// tmcw_cursor
// Cursor registers and character decode: next cursor and store action.
// ----------------------------------------------------------------------------
module tmcw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  localparam int CW = $clog2(COLUMNS),
  localparam int RW = $clog2(ROWS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          code,
  input  logic                upd,
  output logic [CW-1:0]       cur_x,
  output logic [RW-1:0]       cur_y,
  output logic [CW-1:0]       nx,
  output logic [RW-1:0]       ny,
  output tmcw_pkg::tmcw_act_t act
);
  import tmcw_pkg::*;

  logic [CW:0]   xp1;
  logic [CW:0]   tabx;
  logic          last_row;
  logic [RW-1:0] lf_y;

  assign xp1      = {1'b0, cur_x} + (CW+1)'(1);
  assign tabx     = ({1'b0, cur_x} + (CW+1)'(TAB_STOP)) & ~((CW+1)'(TAB_STOP - 1));
  assign last_row = (cur_y == RW'(ROWS - 1));
  assign lf_y     = last_row ? cur_y : cur_y + RW'(1);

  // Decode the code into the next cursor and the store action
  always_comb begin
    nx  = cur_x;
    ny  = cur_y;
    act = '0;
    case (code)
      CH_NL: begin
        nx         = '0;
        ny         = lf_y;
        act.scroll = last_row;
      end
      CH_FF: begin
        nx        = '0;
        ny        = '0;
        act.clear = 1'b1;
      end
      CH_BS: begin
        if (cur_x != '0) begin
          nx = cur_x - CW'(1);
        end
      end
      CH_CR: begin
        nx = '0;
      end
      CH_TAB: begin
        if (tabx >= (CW+1)'(COLUMNS)) begin
          nx         = '0;
          ny         = lf_y;
          act.scroll = last_row;
        end else begin
          nx = tabx[CW-1:0];
        end
      end
      default: begin
        act.store_char = 1'b1;
        if (xp1 >= (CW+1)'(COLUMNS)) begin
          nx         = '0;
          ny         = lf_y;
          act.scroll = last_row;
        end else begin
          nx = xp1[CW-1:0];
        end
      end
    endcase
  end

  // Advance the cursor on an accepted put
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      cur_y <= '0;
    end else if (upd) begin
      cur_x <= nx;
      cur_y <= ny;
    end
  end

endmodule

// ===== sv/text_mode_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_mode_console_writer_core
// Character-cell terminal over a ROWS x COLUMNS frame store with cursor.
// ----------------------------------------------------------------------------
//  channel   signals                                       direction
//  in        in_valid/in_ready, op, char_code,             request in
//            read_row, read_col
//  out       out_valid/out_ready, cursor_col, cursor_row,  result out
//            cursor_linear, cell_char, cell_attr
//  cfg       cfg_valid/cfg_ready, cfg_data                 attribute write
//
//  A printable character or cursor move loads the result when it is taken; a
//  read loads it from S_READ. A scroll and a form feed sweep the frame store
//  one cell a cycle through its single write port, and load the result at the end.
//  After reset a clearing pass blanks the store; no request is taken
//  meanwhile, attribute writes are.
//  A request is taken only while the result register is empty or draining.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  char_code,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic [10:0] cursor_linear,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import tmcw_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int TOTAL = ROWS * COLUMNS;
  localparam int COPY_LEN = COLUMNS * (ROWS - 1);
  localparam int AW = $clog2(TOTAL);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_DRAIN,
    S_BLANK
  } state_t;

  state_t        state;
  logic [AW-1:0] cnt;
  logic          cp_pend;
  logic [AW-1:0] cp_addr;
  logic          rd_oor;
  logic [7:0]    text_attr;
  logic          res_valid;
  logic [6:0]    res_x;
  logic [4:0]    res_y;
  logic [10:0]   res_lin;
  logic [7:0]    res_char;
  logic [7:0]    res_attr;

  logic          in_fire;
  logic          put_fire;
  logic          in_range;
  logic          res_load;
  logic          long_op;
  logic [7:0]    load_char;
  logic [7:0]    load_attr;
  logic [CW-1:0] cur_x;
  logic [RW-1:0] cur_y;
  logic [CW-1:0] nx;
  logic [RW-1:0] ny;
  logic [CW-1:0] src_x;
  logic [RW-1:0] src_y;
  logic [AW-1:0] src_lin;
  logic [AW-1:0] cur_addr;
  tmcw_act_t     act;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  // Handshakes
  assign in_ready  = (state == S_IDLE) && (!res_valid || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign put_fire  = in_fire && (op == OP_PUT);
  assign cfg_ready = 1'b1;
  assign long_op   = act.scroll || act.clear;

  assign in_range = ({3'b000, read_row} < 8'(ROWS)) && ({2'b00, read_col} < 9'(COLUMNS));

  tmcw_cursor #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_cursor (
    .clk  (clk),
    .rst  (rst),
    .code (char_code),
    .upd  (put_fire),
    .cur_x(cur_x),
    .cur_y(cur_y),
    .nx   (nx),
    .ny   (ny),
    .act  (act)
  );

  assign cur_addr = AW'(cur_y) * AW'(COLUMNS) + AW'(cur_x);

  // Frame store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = {RESET_ATTR, BLANK_CHAR};
    ram_raddr = cnt + AW'(COLUMNS);
    case (state)
      S_INIT: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_raddr = AW'(read_row) * AW'(COLUMNS) + AW'(read_col);
        if (put_fire && act.store_char) begin
          ram_we    = 1'b1;
          ram_waddr = cur_addr;
          ram_wdata = {text_attr, char_code};
        end
      end
      S_SCROLL, S_DRAIN: begin
        ram_we    = cp_pend;
        ram_waddr = cp_addr;
        ram_wdata = ram_rdata;
      end
      S_BLANK: begin
        ram_we    = 1'b1;
        ram_wdata = {text_attr, BLANK_CHAR};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tmcw_ram #(
    .WIDTH(16),
    .DEPTH(TOTAL)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Result source: next cursor on a put that starts no sweep, cursor register otherwise
  assign res_load = (put_fire && !long_op) || (state == S_READ) ||
                    ((state == S_BLANK) && (cnt == AW'(TOTAL - 1)));
  assign src_x    = (state == S_IDLE) ? nx : cur_x;
  assign src_y    = (state == S_IDLE) ? ny : cur_y;
  assign src_lin  = AW'(src_y) * AW'(COLUMNS) + AW'(src_x);
  assign load_char = ((state == S_READ) && !rd_oor) ? ram_rdata[7:0] : 8'h00;
  assign load_attr = ((state == S_READ) && !rd_oor) ? ram_rdata[15:8] : 8'h00;

  // Sequencer, attribute register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      cp_pend   <= 1'b0;
      res_valid <= 1'b0;
      text_attr <= RESET_ATTR;
    end else begin
      if (cfg_valid && cfg_ready) begin
        text_attr <= cfg_data;
      end
      cp_pend <= (state == S_SCROLL);
      cp_addr <= cnt;
      case (state)
        S_INIT: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(TOTAL - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cnt    <= '0;
            rd_oor <= !in_range;
            if (op == OP_READ) begin
              state <= S_READ;
            end else if (act.clear) begin
              state <= S_BLANK;
            end else if (act.scroll) begin
              state <= S_SCROLL;
            end
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        S_SCROLL: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(COPY_LEN - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_BLANK;
        end
        S_BLANK: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(TOTAL - 1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (res_load) begin
      res_x    <= 7'(src_x);
      res_y    <= 5'(src_y);
      res_lin  <= 11'(src_lin);
      res_char <= load_char;
      res_attr <= load_attr;
    end
  end

  assign out_valid     = res_valid;
  assign cursor_col    = res_x;
  assign cursor_row    = res_y;
  assign cursor_linear = res_lin;
  assign cell_char     = res_char;
  assign cell_attr     = res_attr;

`ifndef SYNTH
  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_valid || out_ready))
    else $error("result overwritten before it was taken");

  // Hold off requests after a put that starts a sweep
  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    (put_fire && long_op) |=> !in_ready)
    else $error("request taken during a frame sweep");

  // Keep the cursor inside the frame
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_x < CW'(COLUMNS - 1) || cur_x == CW'(COLUMNS - 1)) &&
    (cur_y < RW'(ROWS - 1) || cur_y == RW'(ROWS - 1)))
    else $error("cursor outside the frame");

  // Copy writes only occur while scrolling
  a_copy_phase: assert property (@(posedge clk) disable iff (rst)
    cp_pend |-> (state == S_SCROLL || state == S_DRAIN))
    else $error("copy write outside the scroll sweep");
`endif

endmodule
